// ----- rtl/delimited_text_shape_stats_macros.svh -----
// Assertion macros used by the checker file of the text shape statistics block
`ifndef DELIMITED_TEXT_SHAPE_STATS_MACROS_SVH
`define DELIMITED_TEXT_SHAPE_STATS_MACROS_SVH

// same-cycle implication
`define DTSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtss assertion failed");

// next-cycle implication
`define DTSS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtss assertion failed");

`endif

// ----- rtl/dtss_pkg.sv -----
// Constants for the delimited text shape statistics block
`timescale 1ns / 1ps

package dtss_pkg;

   localparam int unsigned COUNT_WIDTH_DEF = 32;
   localparam int unsigned OUT_WIDTH       = 32;
   localparam logic [7:0]  NEWLINE_BYTE    = 8'h0A;
   localparam logic [7:0]  SEPARATOR_RESET = 8'd44;

endpackage

// ----- rtl/delimited_text_shape_stats.sv -----
// Top level of the delimited text shape statistics block
// Result: a result beat shows on rsp_valid in the cycle after its end-of-file beat is taken.
// Throughput: one request beat per cycle, each byte a single pass of counter updates and
// compares; an end-of-file beat waits only while the previous result is held by rsp_stall.
// Reset: synchronous, active high; clears all counts, sets the rectangular flag,
// drops rsp_valid and returns the separator to 0x2C.
`timescale 1ns / 1ps

module delimited_text_shape_stats #(
   parameter int unsigned COUNT_WIDTH = dtss_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [7:0]                     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_end_of_file,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dtss_pkg::OUT_WIDTH-1:0] rsp_line_total,
   output logic [dtss_pkg::OUT_WIDTH-1:0] rsp_total_bytes,
   output logic [dtss_pkg::OUT_WIDTH-1:0] rsp_longest_line,
   output logic [dtss_pkg::OUT_WIDTH-1:0] rsp_tokens_per_line,
   output logic                           rsp_is_rectangular
);

   localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;

   logic [7:0]             separator_ff;
   logic [COUNT_WIDTH-1:0] line_count_ff, line_count_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [COUNT_WIDTH-1:0] cur_length_ff, cur_length_in;
   logic [COUNT_WIDTH-1:0] max_length_ff, max_length_in;
   logic [COUNT_WIDTH-1:0] cur_tokens_ff, cur_tokens_in;
   logic [COUNT_WIDTH-1:0] max_tokens_ff, max_tokens_in;
   logic [7:0]             last_text_ff, last_text_in;
   logic                   sep_pending_ff, sep_pending_in;
   logic                   inside_line_ff, inside_line_in;
   logic                   rect_ff, rect_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [dtss_pkg::OUT_WIDTH-1:0] line_total_ff, total_bytes_ff;
   logic [dtss_pkg::OUT_WIDTH-1:0] longest_ff, tokens_ff;
   logic                   is_rect_ff;

   logic                   req_accept;
   logic                   eof_accept;
   logic                   is_newline;
   logic                   last_is_sep;
   logic [COUNT_WIDTH-1:0] line_tokens;
   logic [COUNT_WIDTH-1:0] lines_cnt;
   logic [COUNT_WIDTH-1:0] longest_cnt;
   logic [63:0]            lines_wide, bytes_wide, longest_wide, tokens_wide;

   // only an end-of-file beat needs room in the result register
   assign req_stall  = rsp_valid_ff && rsp_stall && req_end_of_file;
   assign req_accept = req_valid && !req_stall;
   assign eof_accept = req_accept && req_end_of_file;

   assign is_newline  = (req_data_byte == dtss_pkg::NEWLINE_BYTE);
   assign last_is_sep = (last_text_ff == separator_ff);

   // token count of the line a newline closes: drop a trailing separator,
   // add the final token unless the line ended on a separator
   always_comb begin
      case ({sep_pending_ff, last_is_sep})
         2'b00:   line_tokens = cur_tokens_ff + CNT_ONE;
         2'b01:   line_tokens = cur_tokens_ff;
         2'b10:   line_tokens = cur_tokens_ff;
         2'b11:   line_tokens = cur_tokens_ff - CNT_ONE;
         default: line_tokens = cur_tokens_ff;
      endcase
   end

   always_comb begin
      line_count_in  = line_count_ff;
      byte_count_in  = byte_count_ff;
      cur_length_in  = cur_length_ff;
      max_length_in  = max_length_ff;
      cur_tokens_in  = cur_tokens_ff;
      max_tokens_in  = max_tokens_ff;
      last_text_in   = last_text_ff;
      sep_pending_in = sep_pending_ff;
      inside_line_in = inside_line_ff;
      rect_in        = rect_ff;
      if (req_accept) begin
         if (req_end_of_file) begin
            line_count_in  = CNT_ZERO;
            byte_count_in  = CNT_ZERO;
            cur_length_in  = CNT_ZERO;
            max_length_in  = CNT_ZERO;
            cur_tokens_in  = CNT_ZERO;
            max_tokens_in  = CNT_ZERO;
            last_text_in   = 8'h00;
            sep_pending_in = 1'b0;
            inside_line_in = 1'b0;
            rect_in        = 1'b1;
         end else if (rect_ff) begin
            sep_pending_in = 1'b0;
            byte_count_in  = byte_count_ff + CNT_ONE;
            if (is_newline) begin
               line_count_in = line_count_ff + CNT_ONE;
               if (cur_length_ff > max_length_ff) begin
                  max_length_in = cur_length_ff;
               end
               if (line_tokens > max_tokens_ff) begin
                  if (max_tokens_ff != CNT_ZERO) begin
                     rect_in = 1'b0;
                  end
                  max_tokens_in = line_tokens;
               end else if (line_tokens < max_tokens_ff) begin
                  rect_in = 1'b0;
               end
               cur_tokens_in  = CNT_ZERO;
               cur_length_in  = CNT_ZERO;
               inside_line_in = 1'b0;
            end else begin
               last_text_in = req_data_byte;
               if (req_data_byte == separator_ff) begin
                  cur_tokens_in  = cur_tokens_ff + CNT_ONE;
                  sep_pending_in = 1'b1;
               end
               cur_length_in  = cur_length_ff + CNT_ONE;
               inside_line_in = 1'b1;
            end
         end
      end
   end

   assign lines_cnt   = line_count_ff + COUNT_WIDTH'(inside_line_ff);
   assign longest_cnt = (cur_length_ff > max_length_ff) ? cur_length_ff : max_length_ff;

   assign lines_wide   = 64'(lines_cnt);
   assign bytes_wide   = 64'(byte_count_ff);
   assign longest_wide = 64'(longest_cnt);
   assign tokens_wide  = 64'(max_tokens_ff);

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || eof_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff   <= dtss_pkg::SEPARATOR_RESET;
         line_count_ff  <= CNT_ZERO;
         byte_count_ff  <= CNT_ZERO;
         cur_length_ff  <= CNT_ZERO;
         max_length_ff  <= CNT_ZERO;
         cur_tokens_ff  <= CNT_ZERO;
         max_tokens_ff  <= CNT_ZERO;
         last_text_ff   <= 8'h00;
         sep_pending_ff <= 1'b0;
         inside_line_ff <= 1'b0;
         rect_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            separator_ff <= csr_wr_data;
         end
         line_count_ff  <= line_count_in;
         byte_count_ff  <= byte_count_in;
         cur_length_ff  <= cur_length_in;
         max_length_ff  <= max_length_in;
         cur_tokens_ff  <= cur_tokens_in;
         max_tokens_ff  <= max_tokens_in;
         last_text_ff   <= last_text_in;
         sep_pending_ff <= sep_pending_in;
         inside_line_ff <= inside_line_in;
         rect_ff        <= rect_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, loaded only by an end-of-file beat
   always_ff @(posedge clock) begin
      if (eof_accept) begin
         line_total_ff  <= lines_wide[dtss_pkg::OUT_WIDTH-1:0];
         total_bytes_ff <= bytes_wide[dtss_pkg::OUT_WIDTH-1:0];
         longest_ff     <= longest_wide[dtss_pkg::OUT_WIDTH-1:0];
         tokens_ff      <= tokens_wide[dtss_pkg::OUT_WIDTH-1:0];
         is_rect_ff     <= rect_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_line_total      = line_total_ff;
   assign rsp_total_bytes     = total_bytes_ff;
   assign rsp_longest_line    = longest_ff;
   assign rsp_tokens_per_line = tokens_ff;
   assign rsp_is_rectangular  = is_rect_ff;

endmodule

// ----- rtl/dtss_checker.sv -----
// Port-level checker for the delimited text shape statistics block, with its bind
`timescale 1ns / 1ps
`include "delimited_text_shape_stats_macros.svh"

module dtss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_end_of_file,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [dtss_pkg::OUT_WIDTH-1:0] rsp_line_total,
   input logic                           rsp_is_rectangular
);

   logic eof_take;
   logic rsp_held;

   assign eof_take = req_valid && !req_stall && req_end_of_file;
   assign rsp_held = rsp_valid && rsp_stall;

   // a data beat never waits
   `DTSS_ASSERT_IMP(a_data_not_stalled, clock, reset, req_valid && !req_end_of_file, !req_stall)

   // every taken end-of-file beat yields a result beat next cycle
   `DTSS_ASSERT_NXT(a_eof_gives_rsp, clock, reset, eof_take, rsp_valid)

   // a result only appears after an end-of-file beat
   `DTSS_ASSERT_IMP(a_rsp_has_cause, clock, reset, $rose(rsp_valid), $past(eof_take))

   // a held result stays valid
   `DTSS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid)

   // a held result keeps its payload
   `DTSS_ASSERT_NXT(a_rsp_data_hold, clock, reset, rsp_held, $stable(rsp_line_total))

endmodule

bind delimited_text_shape_stats dtss_checker u_dtss_checker (.*);
